// ===== hdl/bmhq_pkg.sv =====
`default_nettype none

package bmhq_pkg;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_LAUNCH,
        S_RUN,
        S_HOLD
    } state_t;

    function automatic logic key_gt(input key_t a, input key_t b);
        return a > b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bmhq_cell.sv =====
`default_nettype none

// One heap level: holds the 2**LEVEL entries of that level.
module bmhq_cell
    import bmhq_pkg::*;
#(
    parameter int LEVEL = 0,
    parameter int CW    = 11
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          tok_in_valid,
    input  wire op_t           tok_in_op,
    input  wire key_t          tok_in_key,
    input  wire logic [CW-1:0] tok_in_pos,
    input  wire logic [CW-1:0] tok_in_aux,
    output logic               tok_out_valid,
    output op_t                tok_out_op,
    output key_t               tok_out_key,
    output logic [CW-1:0]      tok_out_pos,
    output logic [CW-1:0]      tok_out_aux,
    input  wire logic          wbi_en,
    input  wire logic [CW-1:0] wbi_idx,
    input  wire key_t          wbi_key,
    output logic               wbo_en,
    output logic [CW-1:0]      wbo_idx,
    output key_t               wbo_key,
    input  wire logic          fetch_en,
    input  wire logic [CW-1:0] fetch_idx,
    output key_t               fetch_key,
    output logic               done
);

    localparam int AW    = (LEVEL == 0) ? 1 : LEVEL;
    localparam int DEPTH = 2 ** AW;

    key_t mem [DEPTH];

    key_t          rda_reg;
    key_t          rdb_reg;
    logic          h_valid_reg;
    op_t           h_op_reg;
    key_t          h_key_reg;
    logic [CW-1:0] h_pos_reg;
    logic [CW-1:0] h_aux_reg;
    logic [AW-1:0] h_idx_reg;

    logic          out_valid_reg;
    op_t           out_op_reg;
    key_t          out_key_reg;
    logic [CW-1:0] out_pos_reg;
    logic [CW-1:0] out_aux_reg;

    logic [CW-1:0] shifted;
    logic [AW-1:0] idx_ins;
    logic [AW-1:0] idx_l;
    logic [AW-1:0] idx_f;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [AW-1:0] h_idx_next;

    logic [CW-1:0] glob;
    logic          present_l;
    logic          present_r;
    logic          pick_r;
    logic          swap;
    key_t          child;
    logic [AW-1:0] cidx;

    logic          we;
    key_t          wkey;
    logic          fwd;
    key_t          fkey;
    logic [CW-1:0] fpos;

    // read side
    always_comb
    begin
        shifted    = tok_in_pos >> (tok_in_aux - CW'(LEVEL));
        idx_ins    = (LEVEL == 0) ? '0 : shifted[AW-1:0];
        idx_l      = AW'({tok_in_pos, 1'b0});
        idx_f      = (LEVEL == 0) ? '0 : fetch_idx[AW-1:0];
        h_idx_next = (tok_in_op == OP_INSERT) ? idx_ins : idx_l;
        addr_a     = fetch_en ? idx_f : h_idx_next;
        addr_b     = idx_l | AW'(1);
    end

    // decide side
    always_comb
    begin
        glob      = CW'(h_idx_reg) | (CW'(1) << LEVEL);
        present_l = glob <= h_aux_reg;
        present_r = glob < h_aux_reg;
        pick_r    = present_r && key_gt(rdb_reg, rda_reg);
        child     = pick_r ? rdb_reg : rda_reg;
        cidx      = h_idx_reg | AW'(pick_r);
        swap      = present_l && key_gt(child, h_key_reg);

        we      = 1'b0;
        wkey    = h_key_reg;
        fwd     = 1'b0;
        fkey    = h_key_reg;
        fpos    = h_pos_reg;
        wbo_en  = 1'b0;
        wbo_idx = h_pos_reg;
        wbo_key = h_key_reg;
        done    = 1'b0;

        if (h_valid_reg)
        begin
            if (h_op_reg == OP_INSERT)
            begin
                if (h_aux_reg == CW'(LEVEL))
                begin
                    we   = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    fwd = 1'b1;
                    if (key_gt(h_key_reg, rda_reg))
                    begin
                        we   = 1'b1;
                        fkey = rda_reg;
                    end
                end
            end
            else if (LEVEL == 0)
            begin
                fwd = 1'b1;
            end
            else
            begin
                wbo_en  = 1'b1;
                wbo_key = swap ? child : h_key_reg;
                if (swap)
                begin
                    fwd  = 1'b1;
                    fpos = CW'(cidx);
                end
                else
                begin
                    done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rda_reg <= mem[addr_a];
        rdb_reg <= mem[addr_b];
        if (wbi_en)
        begin
            mem[wbi_idx[AW-1:0]] <= wbi_key;
        end
        else if (we)
        begin
            mem[h_idx_reg] <= wkey;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            h_valid_reg   <= tok_in_valid;
            out_valid_reg <= fwd;
        end
    end

    always_ff @(posedge clk)
    begin
        h_op_reg    <= tok_in_op;
        h_key_reg   <= tok_in_key;
        h_pos_reg   <= tok_in_pos;
        h_aux_reg   <= tok_in_aux;
        h_idx_reg   <= h_idx_next;
        out_op_reg  <= h_op_reg;
        out_key_reg <= fkey;
        out_pos_reg <= fpos;
        out_aux_reg <= h_aux_reg;
    end

    assign tok_out_valid = out_valid_reg;
    assign tok_out_op    = out_op_reg;
    assign tok_out_key   = out_key_reg;
    assign tok_out_pos   = out_pos_reg;
    assign tok_out_aux   = out_aux_reg;
    assign fetch_key     = rda_reg;

endmodule

`default_nettype wire

// ===== hdl/binary_max_heap_queue_top.sv =====
`default_nettype none

// Channel   Handshake                   Payload
// item      item_valid / item_stall     command, value
// result    result_valid / result_stall removed_value, status, fill_count
//
// One cell per heap level; each level does a registered read, then a compare and write.
// One item in work at a time. A refused item, or a remove that empties the queue,
// goes to the result without a walk through the levels.
// rst_n clears the count and control; level memories are not cleared.
// result_stall holds the result register; the next item is taken meanwhile.
module binary_max_heap_queue_top
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 1024,
    localparam int CW      = $clog2(CAPACITY + 1),
    localparam int NL      = CW,
    localparam int LW      = (NL > 1) ? $clog2(NL) : 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire logic          command,
    input  wire logic [31:0]   value,
    output logic               result_valid,
    input  wire logic          result_stall,
    output logic [31:0]        removed_value,
    output logic [1:0]         status,
    output logic [CW-1:0]      fill_count
);

    state_t        state_reg,  state_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [LW-1:0] lvl_reg,    lvl_next;
    key_t          res_key_reg, res_key_next;
    status_t       res_status_reg, res_status_next;

    logic          launch_valid_reg, launch_valid_next;
    op_t           launch_op_reg,    launch_op_next;
    key_t          launch_key_reg,   launch_key_next;
    logic [CW-1:0] launch_pos_reg,   launch_pos_next;
    logic [CW-1:0] launch_aux_reg,   launch_aux_next;

    logic          out_valid_reg,  out_valid_next;
    key_t          out_key_reg,    out_key_next;
    status_t       out_status_reg, out_status_next;
    logic [CW-1:0] out_count_reg,  out_count_next;

    logic          tok_valid [NL+1];
    op_t           tok_op    [NL+1];
    key_t          tok_key   [NL+1];
    logic [CW-1:0] tok_pos   [NL+1];
    logic [CW-1:0] tok_aux   [NL+1];

    logic          wb_en  [NL+1];
    logic [CW-1:0] wb_idx [NL+1];
    key_t          wb_key [NL+1];

    logic [NL:0]   done_vec;
    logic [NL-1:0] fetch_en_vec;
    key_t          fetch_keys [NL];

    logic          accept;
    logic          full;
    logic          empty;
    logic          fetch_go;
    logic          run_done;
    logic [CW-1:0] pv;
    logic [LW-1:0] lvl_c;
    logic [CW-1:0] fetch_idx;

    assign accept   = item_valid && (state_reg == S_IDLE);
    assign full     = count_reg == CW'(CAPACITY);
    assign empty    = count_reg == '0;
    assign fetch_go = accept && (command == OP_REMOVE) && !empty;
    assign run_done = |done_vec;

    always_comb
    begin
        pv    = (command == OP_REMOVE) ? count_reg : count_reg + CW'(1);
        lvl_c = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (pv[i])
            begin
                lvl_c = LW'(i);
            end
        end
        fetch_idx = pv & ~(CW'(1) << lvl_c);
        for (int i = 0; i < NL; i++)
        begin
            fetch_en_vec[i] = fetch_go && ((i == 0) || (lvl_c == LW'(i)));
        end
    end

    assign tok_valid[0] = launch_valid_reg;
    assign tok_op[0]    = launch_op_reg;
    assign tok_key[0]   = launch_key_reg;
    assign tok_pos[0]   = launch_pos_reg;
    assign tok_aux[0]   = launch_aux_reg;

    // past the deepest level: the carried key lands in the chosen slot
    assign wb_en[NL]    = tok_valid[NL] && (tok_op[NL] == OP_REMOVE);
    assign wb_idx[NL]   = tok_pos[NL];
    assign wb_key[NL]   = tok_key[NL];
    assign done_vec[NL] = tok_valid[NL];

    for (genvar g = 0; g < NL; g++)
    begin : g_level
        if (g == 0)
        begin : g_root
            bmhq_cell #(
                .LEVEL (g),
                .CW    (CW)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .tok_in_valid  (tok_valid[g]),
                .tok_in_op     (tok_op[g]),
                .tok_in_key    (tok_key[g]),
                .tok_in_pos    (tok_pos[g]),
                .tok_in_aux    (tok_aux[g]),
                .tok_out_valid (tok_valid[g+1]),
                .tok_out_op    (tok_op[g+1]),
                .tok_out_key   (tok_key[g+1]),
                .tok_out_pos   (tok_pos[g+1]),
                .tok_out_aux   (tok_aux[g+1]),
                .wbi_en        (wb_en[g+1]),
                .wbi_idx       (wb_idx[g+1]),
                .wbi_key       (wb_key[g+1]),
                .wbo_en        (wb_en[g]),
                .wbo_idx       (wb_idx[g]),
                .wbo_key       (wb_key[g]),
                .fetch_en      (fetch_en_vec[g]),
                .fetch_idx     (fetch_idx),
                .fetch_key     (fetch_keys[g]),
                .done          (done_vec[g])
            );
        end
        else
        begin : g_inner
            bmhq_cell #(
                .LEVEL (g),
                .CW    (CW)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .tok_in_valid  (tok_valid[g]),
                .tok_in_op     (tok_op[g]),
                .tok_in_key    (tok_key[g]),
                .tok_in_pos    (tok_pos[g]),
                .tok_in_aux    (tok_aux[g]),
                .tok_out_valid (tok_valid[g+1]),
                .tok_out_op    (tok_op[g+1]),
                .tok_out_key   (tok_key[g+1]),
                .tok_out_pos   (tok_pos[g+1]),
                .tok_out_aux   (tok_aux[g+1]),
                .wbi_en        (wb_en[g+1]),
                .wbi_idx       (wb_idx[g+1]),
                .wbi_key       (wb_key[g+1]),
                .wbo_en        (wb_en[g]),
                .wbo_idx       (wb_idx[g]),
                .wbo_key       (wb_key[g]),
                .fetch_en      (fetch_en_vec[g]),
                .fetch_idx     (fetch_idx),
                .fetch_key     (fetch_keys[g]),
                .done          (done_vec[g])
            );
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        lvl_next          = lvl_reg;
        res_key_next      = res_key_reg;
        res_status_next   = res_status_reg;
        launch_valid_next = 1'b0;
        launch_op_next    = launch_op_reg;
        launch_key_next   = launch_key_reg;
        launch_pos_next   = launch_pos_reg;
        launch_aux_next   = launch_aux_reg;
        out_valid_next    = out_valid_reg && result_stall;
        out_key_next      = out_key_reg;
        out_status_next   = out_status_reg;
        out_count_next    = out_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_key_next    = '0;
                    res_status_next = ST_DONE;
                    if (command == OP_INSERT)
                    begin
                        if (full)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_HOLD;
                        end
                        else
                        begin
                            count_next        = count_reg + CW'(1);
                            launch_valid_next = 1'b1;
                            launch_op_next    = OP_INSERT;
                            launch_key_next   = key_t'(value);
                            launch_pos_next   = pv;
                            launch_aux_next   = CW'(lvl_c);
                            state_next        = S_RUN;
                        end
                    end
                    else
                    begin
                        if (empty)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_HOLD;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            lvl_next   = lvl_c;
                            state_next = S_LAUNCH;
                        end
                    end
                end
            end
            S_LAUNCH:
            begin
                res_key_next = fetch_keys[0];
                if (count_reg == '0)
                begin
                    state_next = S_HOLD;
                end
                else
                begin
                    launch_valid_next = 1'b1;
                    launch_op_next    = OP_REMOVE;
                    launch_key_next   = fetch_keys[lvl_reg];
                    launch_pos_next   = '0;
                    launch_aux_next   = count_reg;
                    state_next        = S_RUN;
                end
            end
            S_RUN:
            begin
                if (run_done)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_key_next    = res_key_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            launch_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            launch_valid_reg <= launch_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg        <= lvl_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        launch_op_reg  <= launch_op_next;
        launch_key_reg <= launch_key_next;
        launch_pos_reg <= launch_pos_next;
        launch_aux_reg <= launch_aux_next;
        out_key_reg    <= out_key_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign item_stall    = (state_reg != S_IDLE);
    assign result_valid  = out_valid_reg;
    assign removed_value = out_key_reg;
    assign status        = out_status_reg;
    assign fill_count    = out_count_reg;

endmodule

`default_nettype wire

// ===== verif/tb_binary_max_heap_queue_top.sv =====
`timescale 1ns / 1ps

module tb_binary_max_heap_queue_top;
    import bmhq_pkg::*;

    localparam int CAPACITY       = 1024;
    localparam int CW             = $clog2(CAPACITY + 1);
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    localparam key_t KEY_MAX = key_t'(32'h7FFF_FFFF);
    localparam key_t KEY_MIN = key_t'(32'h8000_0000);

    typedef struct packed
    {
        key_t          removed;
        status_t       st;
        logic [CW-1:0] cnt;
    } heap_result_t;

    typedef struct packed
    {
        op_t          op;
        key_t         val;
        logic         typed;
        heap_result_t res;
    } heap_row_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          item_valid   = 1'b0;
    logic          item_stall;
    logic          command      = 1'b0;
    logic [31:0]   value        = '0;
    logic          result_valid;
    logic          result_stall = 1'b0;
    logic [31:0]   removed_value;
    logic [1:0]    status;
    logic [CW-1:0] fill_count;

    key_t         mirror_heap [CAPACITY];
    int           mirror_cnt    = 0;
    int           peak_cnt      = 0;
    heap_result_t result_q [$];
    heap_row_t    dir_rows [$];

    bit calm          = 1'b0;
    int sent_items    = 0;
    int got_results   = 0;
    int full_refused  = 0;
    int empty_refused = 0;
    int fail_count    = 0;
    int idle_cycles   = 0;

    binary_max_heap_queue_top #(.CAPACITY(CAPACITY)) u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .command       (command),
        .value         (value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .removed_value (removed_value),
        .status        (status),
        .fill_count    (fill_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic heap_result_t heap_apply(op_t op, key_t val);
        heap_result_t r;
        int   pos;
        int   par;
        int   lft;
        int   pick;
        key_t tmp;
        r.removed = '0;
        r.st      = ST_DONE;
        if (op == OP_INSERT)
        begin
            if (mirror_cnt >= CAPACITY)
            begin
                r.st = ST_FULL;
            end
            else
            begin
                pos = mirror_cnt;
                mirror_heap[pos] = val;
                while (pos > 0)
                begin
                    par = (pos - 1) / 2;
                    if (!(mirror_heap[pos] > mirror_heap[par]))
                        break;
                    tmp = mirror_heap[pos];
                    mirror_heap[pos] = mirror_heap[par];
                    mirror_heap[par] = tmp;
                    pos = par;
                end
                mirror_cnt++;
            end
        end
        else
        begin
            if (mirror_cnt == 0)
            begin
                r.st = ST_EMPTY;
            end
            else
            begin
                r.removed = mirror_heap[0];
                mirror_cnt--;
                if (mirror_cnt > 0)
                begin
                    mirror_heap[0] = mirror_heap[mirror_cnt];
                    pos = 0;
                    forever
                    begin
                        lft = 2 * pos + 1;
                        if (lft >= mirror_cnt)
                            break;
                        pick = lft;
                        if (lft + 1 < mirror_cnt && mirror_heap[lft + 1] > mirror_heap[lft])
                            pick = lft + 1;
                        if (!(mirror_heap[pick] > mirror_heap[pos]))
                            break;
                        tmp = mirror_heap[pick];
                        mirror_heap[pick] = mirror_heap[pos];
                        mirror_heap[pos] = tmp;
                        pos = pick;
                    end
                end
            end
        end
        if (mirror_cnt > peak_cnt)
            peak_cnt = mirror_cnt;
        r.cnt = mirror_cnt[CW-1:0];
        return r;
    endfunction

    function automatic heap_row_t mk_row(op_t op, key_t val, logic typed,
                                         key_t removed, status_t st, int cnt);
        heap_row_t row;
        row.op          = op;
        row.val         = val;
        row.typed       = typed;
        row.res.removed = removed;
        row.res.st      = st;
        row.res.cnt     = cnt[CW-1:0];
        return row;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 99) < 55)
            return 0;
        return pick_len();
    endfunction

    function automatic key_t pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return key_t'($urandom);
        if (r < 75)
            return key_t'($urandom_range(0, 8)) - 4;
        if (r < 85)
        begin
            case ($urandom_range(0, 4))
                0:       return KEY_MAX;
                1:       return KEY_MIN;
                2:       return '0;
                3:       return -1;
                default: return 1;
            endcase
        end
        if (r < 93)
            return KEY_MAX - key_t'($urandom_range(0, 15));
        return KEY_MIN + key_t'($urandom_range(0, 15));
    endfunction

    task automatic send_item(op_t op, key_t val, logic typed, heap_result_t res);
        int           gap;
        heap_result_t want;
        if (sent_items % 64 == 0)
            calm = ($urandom_range(0, 3) == 0);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        command    <= op;
        value      <= val;
        do
            @(negedge clk);
        while (item_stall);
        want = heap_apply(op, val);
        if (want.st == ST_FULL)
            full_refused++;
        if (want.st == ST_EMPTY)
            empty_refused++;
        if (typed)
            want = res;
        result_q.push_back(want);
        sent_items++;
        @(posedge clk);
    endtask

    // result side back-pressure
    initial
    begin : rx_stall
        int run;
        run = 0;
        forever
        begin
            @(posedge clk);
            if (calm)
            begin
                result_stall <= 1'b0;
                run = 0;
            end
            else if (run > 0)
            begin
                result_stall <= 1'b1;
                run--;
            end
            else
            begin
                result_stall <= 1'b0;
                if ($urandom_range(0, 99) < 25)
                    run = pick_len();
            end
        end
    end

    always @(negedge clk)
    begin : result_check
        heap_result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got_results++;
                idle_cycles = 0;
                if (result_q.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected result removed=%0d status=%0d count=%0d",
                                 $realtime, $signed(removed_value), status, fill_count);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (removed_value !== want.removed || status !== want.st ||
                        fill_count !== want.cnt)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display("%0t: mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, want.removed, want.st, want.cnt,
                                     $signed(removed_value), status, fill_count);
                        fail_count++;
                    end
                end
            end
            else if (item_valid && !item_stall)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
                    $display("FAIL binary_max_heap_queue_top");
                    $finish;
                end
            end
        end
    end

    initial
    begin : main
        op_t op;
        int  ins_pct;

        dir_rows.push_back(mk_row(OP_REMOVE, '0, 1'b1, '0, ST_EMPTY, 0));
        dir_rows.push_back(mk_row(OP_INSERT, KEY_MAX, 1'b1, '0, ST_DONE, 1));
        dir_rows.push_back(mk_row(OP_INSERT, KEY_MIN, 1'b1, '0, ST_DONE, 2));
        dir_rows.push_back(mk_row(OP_INSERT, '0, 1'b1, '0, ST_DONE, 3));
        dir_rows.push_back(mk_row(OP_REMOVE, -1, 1'b1, KEY_MAX, ST_DONE, 2));
        dir_rows.push_back(mk_row(OP_REMOVE, key_t'(32'h5555_5555), 1'b1, '0, ST_DONE, 1));
        dir_rows.push_back(mk_row(OP_REMOVE, '0, 1'b1, KEY_MIN, ST_DONE, 0));
        dir_rows.push_back(mk_row(OP_REMOVE, KEY_MAX, 1'b1, '0, ST_EMPTY, 0));
        dir_rows.push_back(mk_row(OP_INSERT, 5, 1'b0, '0, ST_DONE, 0));
        dir_rows.push_back(mk_row(OP_INSERT, 5, 1'b0, '0, ST_DONE, 0));
        dir_rows.push_back(mk_row(OP_INSERT, 5, 1'b0, '0, ST_DONE, 0));
        dir_rows.push_back(mk_row(OP_INSERT, -1, 1'b0, '0, ST_DONE, 0));
        dir_rows.push_back(mk_row(OP_INSERT, 7, 1'b0, '0, ST_DONE, 0));
        dir_rows.push_back(mk_row(OP_INSERT, 7, 1'b0, '0, ST_DONE, 0));
        dir_rows.push_back(mk_row(OP_INSERT, key_t'(32'hAAAA_AAAA), 1'b0, '0, ST_DONE, 0));
        dir_rows.push_back(mk_row(OP_INSERT, key_t'(32'h5555_5555), 1'b0, '0, ST_DONE, 0));
        repeat (8)
            dir_rows.push_back(mk_row(OP_REMOVE, key_t'($urandom), 1'b0, '0, ST_DONE, 0));
        dir_rows.push_back(mk_row(OP_REMOVE, '0, 1'b1, '0, ST_EMPTY, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);

        // mixed traffic with a drifting insert/remove balance
        for (int seg = 0; seg < 8; seg++)
        begin
            ins_pct = $urandom_range(20, 85);
            for (int k = 0; k < 80; k++)
            begin
                op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
                send_item(op, pick_key(), 1'b0, '0);
            end
        end

        // drain, then push against empty
        while (mirror_cnt > 0)
        begin
            op = ($urandom_range(0, 9) == 0) ? OP_INSERT : OP_REMOVE;
            send_item(op, pick_key(), 1'b0, '0);
        end
        repeat (3) send_item(OP_REMOVE, pick_key(), 1'b0, '0);

        item_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d transfers in, %0d refused full, %0d refused empty, peak fill %0d/%0d.",
                 sent_items, full_refused, empty_refused, peak_cnt, CAPACITY);
        $display("%0d results checked, %0d mismatches.", got_results, fail_count);
        if (fail_count == 0)
            $display("PASS binary_max_heap_queue_top");
        else
            $display("FAIL binary_max_heap_queue_top");
        $finish;
    end

endmodule
